// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the flit traffic endpoint.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fte: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fte: next-cycle check failed");

`endif

// ===== hdl/fte_pkg.sv =====
// Package with the types, codes and constants of the flit traffic endpoint.
package fte_pkg;

    localparam int ACK_QUEUE_DEPTH_DEF = 8;

    localparam int ID_W    = 8;
    localparam int COUNT_W = 16;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] FLIT_BYTES_RST = SIZE_W'(64);

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_GRANT = 2'd3;

    // Error codes of a result word.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_GRANT = 2'd1;
    localparam logic [1:0] ERR_QFULL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIT_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIT_BYTES = 2'd2;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] rx_source_id;
        logic            rx_is_ack;
        logic            rx_is_last;
        logic            link_denied;
    } t_in_word;

    typedef struct packed {
        logic              flit_valid;
        logic [ID_W-1:0]   flit_source_id;
        logic [ID_W-1:0]   flit_dest_id;
        logic              flit_is_ack;
        logic              flit_is_last;
        logic [SIZE_W-1:0] flit_size;
        logic              barrier_request;
        logic [1:0]        error_code;
    } t_out_word;

endpackage

// ===== hdl/fte_in_if.sv =====
// Valid/ready channel that carries input words into the endpoint.
interface fte_in_if;
    import fte_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fte_out_if.sv =====
// Valid/ready channel that carries result words out of the endpoint.
interface fte_out_if;
    import fte_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fte_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/flit_traffic_endpoint_top.sv =====
// Top level of the flit traffic endpoint: control state, ack queue and result register.
//
//   Channel    Dir  Handshake        Carries
//   i_item     in   valid / ready    operation word: tick, start, received flit, grant
//   o_result   out  valid / ready    one result word per input word
//   i_cfg_*    in   write enable     own id, flit_total, flit_bytes
//
// Every accepted input word has its result word in the output register from the next cycle on,
// so the block sustains one word per clock while the result side does not stall.
// An ack pop reads the queue RAM at the head on the accepting edge; the registered read
// data is muxed onto the destination of the ack result at the output.
// Reset is synchronous and clears the control state; the queue RAM is never cleared since
// an entry is only read after it was written. A held result word stalls the input.
module flit_traffic_endpoint_top #(
    parameter int ACK_QUEUE_DEPTH = fte_pkg::ACK_QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fte_in_if.sink                          i_item,
    fte_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [fte_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fte_pkg::CFG_W-1:0]       i_cfg_data
);
    import fte_pkg::*;

    // Queue pointer and fill widths follow the queue depth.
    localparam int AW = (ACK_QUEUE_DEPTH > 1) ? $clog2(ACK_QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(ACK_QUEUE_DEPTH + 1);
    localparam int SW = FW + 1;

    // Configuration registers.
    logic [ID_W-1:0]    r_own_id;
    logic [COUNT_W-1:0] r_flit_total;
    logic [SIZE_W-1:0]  r_flit_bytes;

    // Control state.
    logic [COUNT_W-1:0] r_sent, n_sent;
    logic [AW-1:0]      r_head, n_head;
    logic [FW-1:0]      r_fill, n_fill;
    logic               r_stalled, n_stalled;
    logic               r_running, n_running;

    // Result register; the destination of an ack word comes from the RAM.
    logic               r_out_valid;
    t_out_word          r_res, n_res;

    logic               accept_in;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [ID_W-1:0]    ram_rdata;
    logic [SW-1:0]      tail_sum;
    logic [COUNT_W-1:0] sent_inc;
    logic               pop_go;
    logic               tick_denied;
    logic               res_flit;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept_in    = i_item.valid && i_item.ready;

    // The tail is head plus fill, which stays below twice the depth.
    assign tail_sum  = SW'(r_head) + SW'(r_fill);
    assign ram_waddr = (tail_sum >= SW'(ACK_QUEUE_DEPTH))
                     ? AW'(tail_sum - SW'(ACK_QUEUE_DEPTH)) : AW'(tail_sum);
    assign sent_inc  = r_sent + 1'b1;

    always_comb begin
        n_sent    = r_sent;
        n_head    = r_head;
        n_fill    = r_fill;
        n_stalled = r_stalled;
        n_running = r_running;
        n_res     = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        pop_go    = 1'b0;

        unique case (i_item.data.operation)
            OP_TICK: begin
                if (r_running) begin
                    if (!r_stalled) begin
                        if (r_fill != '0) begin
                            // Acknowledgements go ahead of data words.
                            pop_go               = 1'b1;
                            ram_re               = 1'b1;
                            n_fill               = r_fill - 1'b1;
                            n_head               = (r_head == AW'(ACK_QUEUE_DEPTH - 1))
                                                 ? '0 : r_head + 1'b1;
                            n_res.flit_valid     = 1'b1;
                            n_res.flit_source_id = r_own_id;
                            n_res.flit_is_ack    = 1'b1;
                        end else if (r_sent < r_flit_total) begin
                            n_sent               = sent_inc;
                            n_res.flit_valid     = 1'b1;
                            n_res.flit_source_id = r_own_id;
                            n_res.flit_dest_id   = r_own_id;
                            n_res.flit_is_last   = (sent_inc >= r_flit_total);
                        end
                        if (n_res.flit_valid) begin
                            n_res.flit_size = r_flit_bytes;
                            if (i_item.data.link_denied) begin
                                n_stalled = 1'b1;
                            end
                        end
                    end
                    n_running = (n_sent < r_flit_total) || (n_fill != '0);
                end
            end
            OP_START: begin
                n_running = 1'b1;
            end
            OP_RX: begin
                if (i_item.data.rx_is_last) begin
                    if (r_fill < FW'(ACK_QUEUE_DEPTH)) begin
                        ram_we = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_res.error_code = ERR_QFULL;
                    end
                    n_running = 1'b1;
                end
                n_res.barrier_request = i_item.data.rx_is_ack;
            end
            OP_GRANT: begin
                if (r_stalled) begin
                    n_stalled = 1'b0;
                    n_running = 1'b1;
                end else begin
                    n_res.error_code = ERR_GRANT;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase

        if (!accept_in) begin
            ram_we = 1'b0;
            ram_re = 1'b0;
            pop_go = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id      <= '0;
            r_flit_total  <= '0;
            r_flit_bytes  <= FLIT_BYTES_RST;
            r_sent        <= '0;
            r_head        <= '0;
            r_fill        <= '0;
            r_stalled     <= 1'b0;
            r_running     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OWN_ID:     r_own_id     <= i_cfg_data[ID_W-1:0];
                    CFG_FLIT_TOTAL: r_flit_total <= i_cfg_data[COUNT_W-1:0];
                    CFG_FLIT_BYTES: r_flit_bytes <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                        r_own_id <= r_own_id;
                    end
                endcase
            end
            if (accept_in) begin
                r_sent      <= n_sent;
                r_head      <= n_head;
                r_fill      <= n_fill;
                r_stalled   <= n_stalled;
                r_running   <= n_running;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_res <= n_res;
        end
    end

    // The queue RAM is read at the head when an ack word is issued; its data holds
    // until the next pop, which can only happen once this result has left.
    fte_ram #(
        .WIDTH (ID_W),
        .DEPTH (ACK_QUEUE_DEPTH)
    ) u_ack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.data.rx_source_id),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_result.data = r_res;
        if (r_res.flit_is_ack) begin
            o_result.data.flit_dest_id = ram_rdata;
        end
    end
    assign o_result.valid = r_out_valid;

    assign tick_denied = accept_in && (i_item.data.operation == OP_TICK)
                       && i_item.data.link_denied;
    assign res_flit    = r_out_valid && r_res.flit_valid;

    `include "assert_macros.svh"

    `FTE_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(ACK_QUEUE_DEPTH))
    `FTE_ASSERT_NXT(a_pop_dec, i_clk, i_rst_n, pop_go, r_fill == $past(r_fill) - 1'b1)
    `FTE_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, $rose(r_stalled), $past(tick_denied))
    `FTE_ASSERT_IMP(a_flit_no_err, i_clk, i_rst_n, res_flit, r_res.error_code == ERR_NONE)
endmodule

// ===== bench/tb_flit_traffic_endpoint_top.sv =====
// Self-checking testbench of the flit traffic endpoint with a built-in behavioral predictor.
`timescale 1ns / 1ps

module tb_flit_traffic_endpoint_top;
    import fte_pkg::*;

    localparam int QUEUE_DEPTH = ACK_QUEUE_DEPTH_DEF;
    localparam int WORDS_PER_PHASE = 175;
    localparam int NUM_PHASES = 8;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;

    fte_in_if  item_if ();
    fte_out_if result_if ();

    flit_traffic_endpoint_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_wdata)
    );

    // Words waiting to be offered, and result words that the endpoint still owes us.
    t_in_word  stim_words[$];
    t_out_word expected_words[$];

    // Shadow copy of the endpoint: registers first, then the control state.
    logic [ID_W-1:0]    ep_id;
    logic [COUNT_W-1:0] ep_flit_total;
    logic [SIZE_W-1:0]  ep_flit_bytes;
    logic [COUNT_W-1:0] data_sent;
    logic [ID_W-1:0]    ack_dest_q[$];
    logic               link_stalled;
    logic               ep_running;

    // Handshake shaping: idle percentages per phase and a long receiver hold-off.
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned result_hold_left;
    bit          offering;
    int          fail_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: far longer than the slowest correct run could take.
    initial begin
        #5000000;
        $display("flit_traffic_endpoint_top verification failed");
        $finish;
    end

    // Computes the result word of one accepted input word and advances the shadow state.
    function automatic t_out_word endpoint_result(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.operation)
            OP_TICK: begin
                // A tick only does something while the endpoint runs. Acks leave first,
                // then data flits to ourselves until the configured count is reached.
                if (ep_running) begin
                    if (!link_stalled) begin
                        if (ack_dest_q.size() > 0) begin
                            r.flit_valid     = 1'b1;
                            r.flit_source_id = ep_id;
                            r.flit_dest_id   = ack_dest_q.pop_front();
                            r.flit_is_ack    = 1'b1;
                        end else if (data_sent < ep_flit_total) begin
                            r.flit_valid     = 1'b1;
                            r.flit_source_id = ep_id;
                            r.flit_dest_id   = ep_id;
                            data_sent        = data_sent + 1'b1;
                            r.flit_is_last   = (data_sent >= ep_flit_total);
                        end
                        // The denied bit only matters when a flit actually went out.
                        if (r.flit_valid) begin
                            r.flit_size = ep_flit_bytes;
                            if (w.link_denied) begin
                                link_stalled = 1'b1;
                            end
                        end
                    end
                    ep_running = (data_sent < ep_flit_total) || (ack_dest_q.size() > 0);
                end
            end
            OP_START: begin
                ep_running = 1'b1;
            end
            OP_RX: begin
                // A last flit queues an ack to its source; a full queue drops it.
                if (w.rx_is_last) begin
                    if (ack_dest_q.size() < QUEUE_DEPTH) begin
                        ack_dest_q.push_back(w.rx_source_id);
                    end else begin
                        r.error_code = ERR_QFULL;
                    end
                    ep_running = 1'b1;
                end
                if (w.rx_is_ack) begin
                    r.barrier_request = 1'b1;
                end
            end
            default: begin
                // A grant is only expected while the link stall is set.
                if (link_stalled) begin
                    link_stalled = 1'b0;
                    ep_running   = 1'b1;
                end else begin
                    r.error_code = ERR_GRANT;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word make_word(logic [1:0] op, logic [ID_W-1:0] src,
                                           logic ack, logic last, logic denied);
        t_in_word w;
        w.operation    = op;
        w.rx_source_id = src;
        w.rx_is_ack    = ack;
        w.rx_is_last   = last;
        w.link_denied  = denied;
        return w;
    endfunction

    // Random word: mostly ticks, so that queued work actually drains. The fields that
    // the operation does not use carry random noise.
    function automatic t_in_word rand_word();
        int unsigned pick;
        logic [1:0] op;
        pick = $urandom_range(99);
        if (pick < 55) begin
            op = OP_TICK;
        end else if (pick < 63) begin
            op = OP_START;
        end else if (pick < 89) begin
            op = OP_RX;
        end else begin
            op = OP_GRANT;
        end
        return make_word(op, ID_W'($urandom), ($urandom_range(99) < 30),
                         ($urandom_range(99) < 45), ($urandom_range(99) < 12));
    endfunction

    task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                               input logic [SIZE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Registers are only written while nothing is in flight, so the shadow copy is
    // updated right after the write edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OWN_ID:     ep_id         = value[ID_W-1:0];
            CFG_FLIT_TOTAL: ep_flit_total = value[COUNT_W-1:0];
            CFG_FLIT_BYTES: ep_flit_bytes = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every queued word went in and every result came out, then lets the
    // output register settle.
    task automatic wait_drained();
        while (stim_words.size() != 0 || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // Input side, sampling: an accepted word is predicted and retired at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && item_if.valid && item_if.ready) begin
            expected_words.push_back(endpoint_result(item_if.data));
            void'(stim_words.pop_front());
            offering = 1'b0;
        end
    end

    // Input side, driving: a word once offered stays on the bus until it is taken.
    // Between words the source may idle, and the data lines then carry noise.
    always @(negedge i_clk) begin
        if (!offering) begin
            if (i_rst_n && stim_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                offering = 1'b1;
                item_if.valid <= 1'b1;
                item_if.data  <= stim_words[0];
            end else begin
                item_if.valid <= 1'b0;
                item_if.data  <= t_in_word'($urandom);
            end
        end
    end

    // Result side, driving ready: random stalls, plus a long hold-off when one is armed.
    always @(negedge i_clk) begin
        if (result_hold_left > 0) begin
            result_if.ready  <= 1'b0;
            result_hold_left <= result_hold_left - 1;
        end else begin
            result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result side, checking: every taken result word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_words.size() == 0) begin
                $error("result word arrived with no prediction pending");
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("flit_valid", SIZE_W'(want.flit_valid),
                            SIZE_W'(result_if.data.flit_valid));
                check_field("flit_source_id", SIZE_W'(want.flit_source_id),
                            SIZE_W'(result_if.data.flit_source_id));
                check_field("flit_dest_id", SIZE_W'(want.flit_dest_id),
                            SIZE_W'(result_if.data.flit_dest_id));
                check_field("flit_is_ack", SIZE_W'(want.flit_is_ack),
                            SIZE_W'(result_if.data.flit_is_ack));
                check_field("flit_is_last", SIZE_W'(want.flit_is_last),
                            SIZE_W'(result_if.data.flit_is_last));
                check_field("flit_size", want.flit_size, result_if.data.flit_size);
                check_field("barrier_request", SIZE_W'(want.barrier_request),
                            SIZE_W'(result_if.data.barrier_request));
                check_field("error_code", SIZE_W'(want.error_code),
                            SIZE_W'(result_if.data.error_code));
            end
        end
    end

    initial begin
        int unsigned queued;
        int unsigned chunk;
        bit held;
        logic [CFG_W-1:0] total;

        // Every input of the block is known from time zero.
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_wdata        = '0;
        item_if.valid    = 1'b0;
        item_if.data     = '0;
        result_if.ready  = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        result_hold_left = 0;
        offering         = 1'b0;
        fail_count       = 0;
        held             = 1'b0;

        // Shadow state after reset; flit_bytes comes out of reset as 64.
        ep_id         = '0;
        ep_flit_total = '0;
        ep_flit_bytes = FLIT_BYTES_RST;
        data_sent     = '0;
        link_stalled  = 1'b0;
        ep_running    = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. flit_bytes is left at its reset value on purpose.
        write_reg(CFG_OWN_ID, 16'h005A);
        write_reg(CFG_FLIT_TOTAL, 16'd3);
        // Denied tick while idle is ignored, and a grant with no stall is flagged.
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1));
        stim_words.push_back(make_word(OP_GRANT, 8'h00, 1'b0, 1'b0, 1'b0));
        // A received ack raises the barrier request without touching the run state.
        stim_words.push_back(make_word(OP_RX, 8'hFF, 1'b1, 1'b0, 1'b0));
        stim_words.push_back(make_word(OP_START, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
        // The second data flit is denied: the next tick sends nothing, a grant clears
        // the stall, and a second grant is unexpected again.
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1));
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_words.push_back(make_word(OP_GRANT, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_words.push_back(make_word(OP_GRANT, 8'h00, 1'b0, 1'b0, 1'b0));
        // The final data flit is marked last, after which the endpoint stops.
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
        // One more received last flit than the ack queue holds: the overflow is flagged
        // but still restarts the endpoint.
        stim_words.push_back(make_word(OP_RX, 8'h00, 1'b0, 1'b1, 1'b0));
        stim_words.push_back(make_word(OP_RX, 8'hFF, 1'b1, 1'b1, 1'b0));
        for (int i = 2; i <= QUEUE_DEPTH; i++) begin
            stim_words.push_back(make_word(OP_RX, ID_W'($urandom), 1'b0, 1'b1, 1'b0));
        end
        repeat (4) stim_words.push_back(make_word(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // Random part. The idling mode cycles through: none, source idle half the time,
        // sink stalling half the time, and both a third of the time.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase

            // Phase 1 takes the low extremes and phase 2 the high ones. Elsewhere the
            // transfer length sits a little above what was already sent, so that the
            // last data flit shows up again.
            if (phase == 1) begin
                total = 16'd0;
                write_reg(CFG_OWN_ID, 16'd0);
                write_reg(CFG_FLIT_BYTES, 16'd1);
            end else if (phase == 2) begin
                total = 16'hFFFF;
                write_reg(CFG_OWN_ID, 16'd255);
                write_reg(CFG_FLIT_BYTES, 16'd4096);
            end else begin
                total = CFG_W'(data_sent + $urandom_range(1, 60));
                write_reg(CFG_OWN_ID, CFG_W'($urandom_range(255)));
                write_reg(CFG_FLIT_BYTES, CFG_W'($urandom_range(1, 4096)));
            end
            write_reg(CFG_FLIT_TOTAL, total);

            // Words go in bursts; after each burst the source waits for every result.
            queued = 0;
            while (queued < WORDS_PER_PHASE) begin
                chunk = $urandom_range(10, 60);
                repeat (chunk) stim_words.push_back(rand_word());
                queued += chunk;
                // Once, with the source never idling, the sink holds off long enough for
                // the output register to fill and back-pressure the input.
                if (phase == 4 && !held) begin
                    @(posedge i_clk);
                    result_hold_left = 250;
                    held = 1'b1;
                end
                wait_drained();
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("flit_traffic_endpoint_top verification clean");
        end else begin
            $display("flit_traffic_endpoint_top verification failed");
        end
        $finish;
    end

endmodule

// ===== flit_traffic_endpoint_top.f =====
+incdir+hdl
hdl/fte_pkg.sv
hdl/fte_in_if.sv
hdl/fte_out_if.sv
hdl/fte_ram.sv
hdl/flit_traffic_endpoint_top.sv
bench/tb_flit_traffic_endpoint_top.sv
